### hw/rtl/mec_pkg.sv
// Shared constants and types for the escape-time color core.
// Fixed-point widths, iteration block size and register indexes.
// No dependencies.
package mec_pkg;

  // Point and orbit format: signed Q4.28
  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned Q_W        = 32;
  // Orbit registers hold one step past the escape radius
  localparam int unsigned Z_W        = 34;
  // Square of a bounded orbit value, unsigned
  localparam int unsigned SQ_W       = 59;
  // Difference of two squares, signed
  localparam int unsigned DIFF_W     = 60;
  localparam int unsigned MUL_W      = 64;
  // Radius 2 in Q4.28, radius squared 4 in Q8.56
  localparam longint      Q_TWO      = 64'sd1 << 29;
  localparam longint      Q56_FOUR   = 64'sd1 << 58;

  // Iterations run in whole blocks of this many
  localparam int unsigned ITER_BLOCK = 10;
  localparam int unsigned BLK_W      = $clog2(ITER_BLOCK + 1);

  // Exact iteration counter and configuration widths
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned MAXIT_W    = 16;
  localparam int unsigned OFF_W      = 10;
  localparam int unsigned OFF_FRAC   = 8;
  localparam int unsigned COL_W      = 12;

  // Palette: index = floor(num * PALETTE / (max * 256)) = floor(num * 3 / max)
  localparam int unsigned PALETTE    = 768;
  localparam int unsigned PAL_TOP    = 767;
  localparam int unsigned PAL_SCALE  = PALETTE / (1 << OFF_FRAC);
  localparam int unsigned COLOR_W    = 10;
  localparam int unsigned NUM_W      = CNT_W + OFF_FRAC + 2;
  localparam int unsigned DIV_CNT_W  = $clog2(COLOR_W);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_START_X  = 3'd0,
    CFG_STEP_X   = 3'd1,
    CFG_ROW_Y    = 3'd2,
    CFG_MAX_ITER = 3'd3,
    CFG_COLOR_OFF = 3'd4
  } cfg_idx_e;

endpackage

### hw/rtl/mandelbrot_escape_color_core.sv
// Escape-time point evaluator with smooth palette index, top level.
// Iterates z = z^2 + c on one shared 32x32 multiplier under a sequencer.
// Depends on mec_pkg.

// Each beat on the input carries a pixel column; the core forms
// c = (start_x + column*step_x, row_y), iterates the orbit in blocks of
// ITER_BLOCK and returns one beat with the iteration count and a palette
// index. One item passes the setup states CMUL and CSAT, then XY, UPD,
// SQX, SQY and CHK per iteration while the orbit is bounded (SQX goes to
// STEP in the iteration in which a coordinate leaves the radius), STEP
// once per remaining iteration of the block after escape, then the
// palette divide and the result load. The single multiplier sets the pace,
// as each iteration needs three products from it. A new beat is taken
// only while the sequencer is idle; a finished result may still wait in
// the output register meanwhile. Configuration writes are always ready
// and must only be issued while the core is idle.
module mandelbrot_escape_color_core
  import mec_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [31:0]               cfg_data_i,
  // pixel input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [COL_W-1:0]          pixel_column_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [COLOR_W-1:0]        color_index_o,
  output logic [MAXIT_W-1:0]        iteration_count_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CSAT,
    ST_XY,
    ST_UPD,
    ST_SQX,
    ST_SQY,
    ST_CHK,
    ST_STEP,
    ST_CNUM,
    ST_CMUL3,
    ST_COVF,
    ST_DIV,
    ST_FIN
  } state_e;

  localparam logic signed [Z_W-1:0]   Z_TWO     = Z_W'(Q_TWO);
  localparam logic signed [Z_W-1:0]   Z_NTWO    = -Z_TWO;
  localparam logic [DIFF_W-1:0]       ESC_LIMIT = DIFF_W'(Q56_FOUR);
  localparam logic signed [MUL_W-1:0] CR_MAX    = MUL_W'(64'sd2147483647);
  localparam logic signed [MUL_W-1:0] CR_MIN    = -MUL_W'(64'sd2147483648);

  // configuration registers
  logic signed [Q_W-1:0]   start_x_q, step_x_q, row_y_q;
  logic [MAXIT_W-1:0]      max_iter_q;
  logic [OFF_W-1:0]        color_off_q;

  // control state
  state_e                  state_q, state_d;
  logic                    escaped_q, escaped_d;
  logic                    done_q, done_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [BLK_W-1:0]        blk_q, blk_d;
  logic [DIV_CNT_W-1:0]    div_cnt_q, div_cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [COLOR_W-1:0]      color_q, color_d;
  logic [MAXIT_W-1:0]      icount_q, icount_d;

  // datapath registers
  logic [COL_W-1:0]        col_q, col_d;
  logic signed [Q_W-1:0]   cr_q, cr_d;
  logic signed [Z_W-1:0]   zx_q, zx_d, zy_q, zy_d;
  logic [SQ_W-1:0]         sqx_q, sqx_d, sqy_q, sqy_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [MUL_W-1:0] mul_q;
  logic signed [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0]        rem_q, rem_d, dvs_q, dvs_d;
  logic [COLOR_W-1:0]      quo_q, quo_d;

  // shared multiplier
  logic signed [Q_W-1:0]   mul_a, mul_b;
  logic signed [MUL_W-1:0] mul_p;

  logic                    in_acc;
  logic                    sum_esc, esc_sel, done_n, blk_last, fin_n;
  logic signed [MUL_W-1:0] cr_sum;

  assign cfg_ready_o       = 1'b1;
  assign in_stall_o        = (state_q != ST_IDLE);
  assign in_acc            = in_valid_i && !in_stall_o;
  assign out_valid_o       = out_valid_q;
  assign color_index_o     = color_q;
  assign iteration_count_o = icount_q;

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_CMUL: begin
        mul_a = $signed({{(Q_W-COL_W){1'b0}}, col_q});
        mul_b = step_x_q;
      end
      ST_XY: begin
        mul_a = zx_q[Q_W-1:0];
        mul_b = zy_q[Q_W-1:0];
      end
      ST_SQX: begin
        mul_a = zx_q[Q_W-1:0];
        mul_b = zx_q[Q_W-1:0];
      end
      ST_SQY: begin
        mul_a = zy_q[Q_W-1:0];
        mul_b = zy_q[Q_W-1:0];
      end
      ST_CMUL3: begin
        mul_a = $signed({{(Q_W-NUM_W){num_q[NUM_W-1]}}, num_q});
        mul_b = Q_W'(PAL_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Real part before saturation, and escape test on the squared radius
  assign cr_sum  = $signed({{(MUL_W-Q_W){start_x_q[Q_W-1]}}, start_x_q}) + mul_q;
  assign sum_esc = ({1'b0, sqx_q} + {1'b0, mul_q[SQ_W-1:0]}) > ESC_LIMIT;

  // End-of-iteration bookkeeping: note escape or limit, advance counters
  assign esc_sel  = (state_q == ST_CHK) ? sum_esc : escaped_q;
  assign done_n   = done_q || esc_sel || (count_q >= {1'b0, max_iter_q});
  assign blk_last = (blk_q == BLK_W'(ITER_BLOCK - 1));
  assign fin_n    = blk_last && done_n;

  // Sequencer and datapath next values
  always_comb begin
    state_d     = state_q;
    escaped_d   = escaped_q;
    done_d      = done_q;
    count_d     = count_q;
    blk_d       = blk_q;
    div_cnt_d   = div_cnt_q;
    color_d     = color_q;
    icount_d    = icount_q;
    col_d       = col_q;
    cr_d        = cr_q;
    zx_d        = zx_q;
    zy_d        = zy_q;
    sqx_d       = sqx_q;
    sqy_d       = sqy_q;
    diff_d      = diff_q;
    num_d       = num_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    // drop the result once the sink takes it
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          col_d     = pixel_column_i;
          zx_d      = '0;
          zy_d      = '0;
          sqx_d     = '0;
          sqy_d     = '0;
          escaped_d = 1'b0;
          done_d    = 1'b0;
          count_d   = '0;
          blk_d     = '0;
          state_d   = ST_CMUL;
        end
      end
      ST_CMUL: begin
        state_d = ST_CSAT;
      end
      ST_CSAT: begin
        // saturate the real part to Q4.28
        if (cr_sum > CR_MAX) begin
          cr_d = CR_MAX[Q_W-1:0];
        end else if (cr_sum < CR_MIN) begin
          cr_d = CR_MIN[Q_W-1:0];
        end else begin
          cr_d = cr_sum[Q_W-1:0];
        end
        state_d = ST_XY;
      end
      ST_XY: begin
        diff_d  = $signed({1'b0, sqx_q}) - $signed({1'b0, sqy_q});
        state_d = ST_UPD;
      end
      ST_UPD: begin
        // floor shifts back to 28 fraction bits; 2xy uses one bit less
        zx_d = Z_W'(diff_q >>> FRAC_BITS)
             + $signed({{(Z_W-Q_W){cr_q[Q_W-1]}}, cr_q});
        zy_d = Z_W'(mul_q >>> (FRAC_BITS - 1))
             + $signed({{(Z_W-Q_W){row_y_q[Q_W-1]}}, row_y_q});
        state_d = ST_SQX;
      end
      ST_SQX: begin
        if (zx_q > Z_TWO || zx_q < Z_NTWO || zy_q > Z_TWO || zy_q < Z_NTWO) begin
          escaped_d = 1'b1;
          state_d   = ST_STEP;
        end else begin
          state_d   = ST_SQY;
        end
      end
      ST_SQY: begin
        sqx_d   = mul_q[SQ_W-1:0];
        state_d = ST_CHK;
      end
      ST_CHK, ST_STEP: begin
        if (state_q == ST_CHK) begin
          sqy_d     = mul_q[SQ_W-1:0];
          escaped_d = sum_esc;
        end
        done_d  = done_n;
        count_d = count_q + CNT_W'(1);
        blk_d   = blk_last ? '0 : blk_q + BLK_W'(1);
        if (fin_n) begin
          state_d = ST_CNUM;
        end else if (esc_sel) begin
          state_d = ST_STEP;
        end else begin
          state_d = ST_XY;
        end
      end
      ST_CNUM: begin
        num_d   = $signed({2'b00, count_q, {OFF_FRAC{1'b0}}})
                - $signed({{(NUM_W-OFF_W){1'b0}}, color_off_q});
        state_d = ST_CMUL3;
      end
      ST_CMUL3: begin
        if (max_iter_q == '0 || num_q <= '0) begin
          quo_d   = '0;
          state_d = ST_FIN;
        end else begin
          state_d = ST_COVF;
        end
      end
      ST_COVF: begin
        // quotient of 1024 or more clamps at once
        if (mul_q >= $signed(MUL_W'({max_iter_q, {COLOR_W{1'b0}}}))) begin
          quo_d   = COLOR_W'(PAL_TOP);
          state_d = ST_FIN;
        end else begin
          rem_d     = mul_q[NUM_W-1:0];
          dvs_d     = NUM_W'({max_iter_q, {(COLOR_W-1){1'b0}}});
          quo_d     = '0;
          div_cnt_d = '0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        // one restoring divide step per cycle
        if (rem_q >= dvs_q) begin
          rem_d = rem_q - dvs_q;
          quo_d = {quo_q[COLOR_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[COLOR_W-2:0], 1'b0};
        end
        dvs_d     = dvs_q >> 1;
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        if (div_cnt_q == DIV_CNT_W'(COLOR_W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!(out_valid_q && out_stall_i)) begin
          color_d     = (quo_q > COLOR_W'(PAL_TOP)) ? COLOR_W'(PAL_TOP) : quo_q;
          icount_d    = count_q[CNT_W-1] ? {MAXIT_W{1'b1}} : count_q[MAXIT_W-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      escaped_q   <= 1'b0;
      done_q      <= 1'b0;
      count_q     <= '0;
      blk_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      color_q     <= '0;
      icount_q    <= '0;
    end else begin
      state_q     <= state_d;
      escaped_q   <= escaped_d;
      done_q      <= done_d;
      count_q     <= count_d;
      blk_q       <= blk_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      color_q     <= color_d;
      icount_q    <= icount_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q   <= -32'sd536870912;
      step_x_q    <= 32'sd262144;
      row_y_q     <= '0;
      max_iter_q  <= MAXIT_W'(1000);
      color_off_q <= OFF_W'(810);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_START_X:   start_x_q   <= cfg_data_i;
        CFG_STEP_X:    step_x_q    <= cfg_data_i;
        CFG_ROW_Y:     row_y_q     <= cfg_data_i;
        CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[MAXIT_W-1:0];
        CFG_COLOR_OFF: color_off_q <= cfg_data_i[OFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    cr_q   <= cr_d;
    zx_q   <= zx_d;
    zy_q   <= zy_d;
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    diff_q <= diff_d;
    mul_q  <= mul_p;
    num_q  <= num_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
  end

  // Palette index never leaves the palette
  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> color_index_o <= COLOR_W'(PAL_TOP))
    else $error("color index above palette top");

  // Escape is sticky until the next pixel
  a_escape_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    escaped_q && !in_acc |=> escaped_q)
    else $error("escape flag dropped mid-pixel");

  // An escaped orbit is frozen
  a_orbit_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    escaped_q && !in_acc |=> $stable(zx_q) && $stable(zy_q))
    else $error("orbit moved after escape");

  // Results only come out at a block boundary once the loop is done
  a_block_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |-> done_q && blk_q == '0)
    else $error("result before end of an iteration block");

  // A free output register takes the result in the next cycle
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && !(out_valid_q && out_stall_i) |=>
      out_valid_o && state_q == ST_IDLE)
    else $error("finished result not loaded");

endmodule
